// ----- design/jrb_pkg.sv -----
`default_nettype none

package jrb_pkg;

  localparam int CAPACITY       = 64;
  localparam int MIN_DELAY_MS   = 20;
  localparam int MAX_DELAY_MS   = 1000;
  localparam int RESET_DELAY_MS = 100;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int DELAY_W = 10;
  localparam int OCC_W   = 7;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PAUSE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_RELEASED = 3'd2,
    ST_SNAPSHOT = 3'd3,
    ST_NOTHING  = 3'd4
  } status_e;

  // what a cell loads on the update cycle
  typedef enum logic [1:0] {
    MV_HOLD      = 2'd0,
    MV_LOAD      = 2'd1,
    MV_FROM_PREV = 2'd2,
    MV_FROM_NEXT = 2'd3
  } move_e;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] media_time;
    logic [31:0] handle;
    logic [15:0] size;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    logic capture;  // latch per-cell order compare
    logic push;     // insert new entry at its sorted place
    logic pop;      // drop head, shift toward head
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ----- design/jitter_reorder_buffer_core.sv -----
// Jitter buffer of frame descriptors, kept sorted by wrapping 16-bit
// sequence number in a row of cells (cell 0 is the head).
// Input channel: in_valid_i/in_ready_o with action, frame fields, now_ms
// and pause_flag. Output channel: out_valid_o/out_ready_i with status,
// frame fields and occupancy; exactly one result word per input word.
// Config: cfg_we_i writes release_delay_ms, clamped to the min/max delay.
// For each word, on the accept edge every cell latches its order compare
// against the new sequence number; in the update cycle, which waits
// while the output register is still full, the first-position search over
// those bits steers the shift of the chain, or the head drops out, and the
// result is loaded into the output register.
// in_ready_o is high only while no word is in the update cycle; a word
// may be accepted while the previous result still waits downstream, but
// its update cycle holds until the output register is free, so a stalled
// receiver stalls the block after one more word.
// Reset clears count, pause and snapshot state and sets the delay to
// 100 ms; slot contents are not cleared and need no clearing pass.
`default_nettype none

module jitter_reorder_buffer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] seq_i,
  input  wire logic [31:0] media_time_i,
  input  wire logic [31:0] payload_handle_i,
  input  wire logic [15:0] payload_size_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        pause_flag_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      frame_seq_o,
  output logic [31:0]      frame_media_time_o,
  output logic [31:0]      frame_handle_o,
  output logic [15:0]      frame_size_o,
  output logic [6:0]       occupancy_o,

  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        pause_flag;
    logic [31:0] now_ms;
  } item_t;

  state_e                        state_q, state_d;
  item_t                         item_q;
  jrb_pkg::entry_t               new_q;
  logic [jrb_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          paused_q, paused_d;
  logic                          snap_valid_q, snap_valid_d;
  jrb_pkg::entry_t               snap_q, snap_d;
  logic [jrb_pkg::DELAY_W-1:0]   delay_q, delay_d;
  logic                          out_valid_q, out_valid_d;
  logic [2:0]                    status_q, status_d;
  jrb_pkg::entry_t               frame_q, frame_d;
  logic [jrb_pkg::OCC_W-1:0]     occ_q, occ_d;

  logic                          accept;
  logic                          go;
  logic                          push_go;
  logic                          pop_go;
  logic [31:0]                   age;
  jrb_pkg::entry_t               head;
  jrb_pkg::chain_ctrl_t          chain_ctrl;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign go         = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign age        = item_q.now_ms - head.arrival;

  always_comb begin
    delay_d = delay_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < jrb_pkg::DELAY_W'(jrb_pkg::MIN_DELAY_MS)) begin
        delay_d = jrb_pkg::DELAY_W'(jrb_pkg::MIN_DELAY_MS);
      end else if (cfg_wdata_i > jrb_pkg::DELAY_W'(jrb_pkg::MAX_DELAY_MS)) begin
        delay_d = jrb_pkg::DELAY_W'(jrb_pkg::MAX_DELAY_MS);
      end else begin
        delay_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    paused_d     = paused_q;
    snap_valid_d = snap_valid_q;
    snap_d       = snap_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    frame_d      = frame_q;
    occ_d        = occ_q;
    push_go      = 1'b0;
    pop_go       = 1'b0;

    if (accept) begin
      state_d = S_EXEC;
    end

    if (go) begin
      state_d     = S_IDLE;
      out_valid_d = 1'b1;
      status_d    = jrb_pkg::ST_NOTHING;
      frame_d     = '0;
      case (item_q.action)
        jrb_pkg::ACT_PUSH: begin
          if (count_q >= jrb_pkg::CNT_W'(jrb_pkg::CAPACITY)) begin
            status_d = jrb_pkg::ST_FULL;
          end else begin
            push_go  = 1'b1;
            count_d  = count_q + jrb_pkg::CNT_W'(1);
            status_d = jrb_pkg::ST_DONE;
          end
        end
        jrb_pkg::ACT_POP: begin
          if (paused_q) begin
            if (snap_valid_q) begin
              status_d = jrb_pkg::ST_SNAPSHOT;
              frame_d  = snap_q;
            end
          end else if (count_q != '0 && age >= 32'(delay_q)) begin
            pop_go   = 1'b1;
            count_d  = count_q - jrb_pkg::CNT_W'(1);
            status_d = jrb_pkg::ST_RELEASED;
            frame_d  = head;
          end
        end
        jrb_pkg::ACT_PAUSE: begin
          if (item_q.pause_flag && !paused_q) begin
            snap_valid_d = (count_q != '0);
            if (count_q != '0) begin
              snap_d = head;
            end
            paused_d = 1'b1;
          end else if (!item_q.pause_flag && paused_q) begin
            paused_d = 1'b0;
          end
          status_d = jrb_pkg::ST_DONE;
        end
        default: begin
          status_d = jrb_pkg::ST_NOTHING;
        end
      endcase
      frame_d.arrival = '0;
      occ_d           = jrb_pkg::OCC_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      paused_q     <= 1'b0;
      snap_valid_q <= 1'b0;
      snap_q       <= '0;
      delay_q      <= jrb_pkg::DELAY_W'(jrb_pkg::RESET_DELAY_MS);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      paused_q     <= paused_d;
      snap_valid_q <= snap_valid_d;
      snap_q       <= snap_d;
      delay_q      <= delay_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action     <= action_i;
      item_q.pause_flag <= pause_flag_i;
      item_q.now_ms     <= now_ms_i;
      new_q.seq         <= seq_i;
      new_q.media_time  <= media_time_i;
      new_q.handle      <= payload_handle_i;
      new_q.size        <= payload_size_i;
      new_q.arrival     <= now_ms_i;
    end
    status_q <= status_d;
    frame_q  <= frame_d;
    occ_q    <= occ_d;
  end

  assign chain_ctrl.capture = accept;
  assign chain_ctrl.push    = push_go;
  assign chain_ctrl.pop     = pop_go;

  jrb_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (chain_ctrl),
    .cmp_seq_i (seq_i),
    .count_i   (count_q),
    .new_i     (new_q),
    .head_o    (head)
  );

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign frame_seq_o        = frame_q.seq;
  assign frame_media_time_o = frame_q.media_time;
  assign frame_handle_o     = frame_q.handle;
  assign frame_size_o       = frame_q.size;
  assign occupancy_o        = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= jrb_pkg::CNT_W'(jrb_pkg::CAPACITY))
    else $error("held count above capacity");

  a_count_grows_by_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (count_d != count_q) |-> push_go || pop_go)
    else $error("count moved without a chain shift");

  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_go || pop_go) |-> go && !(push_go && pop_go))
    else $error("chain shift outside an update cycle");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> out_valid_q && state_q == S_IDLE)
    else $error("update cycle left no result");

endmodule

`default_nettype wire

// ----- design/jrb_cell.sv -----
`default_nettype none

module jrb_cell (
  input  wire logic            clk_i,
  input  wire logic            capture_i,
  input  wire logic            live_i,
  input  wire logic [15:0]     cmp_seq_i,
  input  wire jrb_pkg::move_e  move_i,
  input  wire jrb_pkg::entry_t new_i,
  input  wire jrb_pkg::entry_t prev_i,
  input  wire jrb_pkg::entry_t next_i,
  output jrb_pkg::entry_t      entry_o,
  output logic                 before_o
);

  jrb_pkg::entry_t entry_q, entry_d;
  logic            before_q, before_d;
  logic [15:0]     diff;

  // held entry lies before the new word under 16-bit wrap
  assign diff     = entry_q.seq - cmp_seq_i;
  assign before_d = capture_i ? (live_i & diff[15]) : before_q;

  always_comb begin
    case (move_i)
      jrb_pkg::MV_HOLD:      entry_d = entry_q;
      jrb_pkg::MV_LOAD:      entry_d = new_i;
      jrb_pkg::MV_FROM_PREV: entry_d = prev_i;
      jrb_pkg::MV_FROM_NEXT: entry_d = next_i;
      default:               entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q  <= entry_d;
    before_q <= before_d;
  end

  assign entry_o  = entry_q;
  assign before_o = before_q;

endmodule

`default_nettype wire

// ----- design/jrb_chain.sv -----
`default_nettype none

module jrb_chain (
  input  wire logic                       clk_i,
  input  wire jrb_pkg::chain_ctrl_t       ctrl_i,
  input  wire logic [15:0]                cmp_seq_i,
  input  wire logic [jrb_pkg::CNT_W-1:0]  count_i,
  input  wire jrb_pkg::entry_t            new_i,
  output jrb_pkg::entry_t                 head_o
);

  localparam int N = jrb_pkg::CAPACITY;

  jrb_pkg::entry_t entry [N];
  jrb_pkg::move_e  move  [N];
  logic [N-1:0]    earlier;
  logic [N-1:0]    above_all;

  // bit k set when every cell below k holds an earlier word:
  // the trailing-ones mask of the earlier vector plus its first zero
  assign above_all = earlier ^ (earlier + N'(1));

  for (genvar k = 0; k < N; k++) begin : g_cell
    jrb_pkg::entry_t prev_e, next_e;
    logic            live;

    assign live = (jrb_pkg::CNT_W'(k) < count_i);

    if (k == 0) begin : g_first
      assign prev_e = new_i;
    end else begin : g_prev
      assign prev_e = entry[k-1];
    end

    if (k == N - 1) begin : g_last
      assign next_e = entry[k];
    end else begin : g_next
      assign next_e = entry[k+1];
    end

    always_comb begin
      move[k] = jrb_pkg::MV_HOLD;
      if (ctrl_i.push) begin
        if (!above_all[k]) begin
          move[k] = jrb_pkg::MV_FROM_PREV;
        end else if (!earlier[k]) begin
          move[k] = jrb_pkg::MV_LOAD;
        end
      end else if (ctrl_i.pop) begin
        move[k] = jrb_pkg::MV_FROM_NEXT;
      end
    end

    jrb_cell u_cell (
      .clk_i     (clk_i),
      .capture_i (ctrl_i.capture),
      .live_i    (live),
      .cmp_seq_i (cmp_seq_i),
      .move_i    (move[k]),
      .new_i     (new_i),
      .prev_i    (prev_e),
      .next_i    (next_e),
      .entry_o   (entry[k]),
      .before_o  (earlier[k])
    );
  end

  assign head_o = entry[0];

endmodule

`default_nettype wire

// ----- sim/jitter_reorder_buffer_core_tb.sv -----
`timescale 1ns / 100ps

module jitter_reorder_buffer_core_tb;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    jrb_pkg::status_e status;
    logic [15:0]      seq;
    logic [31:0]      media_time;
    logic [31:0]      handle;
    logic [15:0]      size;
    logic [6:0]       occupancy;
  } frame_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [15:0] seq_i;
  logic [31:0] media_time_i;
  logic [31:0] payload_handle_i;
  logic [15:0] payload_size_i;
  logic [31:0] now_ms_i;
  logic        pause_flag_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [15:0] frame_seq_o;
  logic [31:0] frame_media_time_o;
  logic [31:0] frame_handle_o;
  logic [15:0] frame_size_o;
  logic [6:0]  occupancy_o;
  logic        cfg_we_i;
  logic [9:0]  cfg_wdata_i;

  // predicted block state
  jrb_pkg::entry_t held_q[$];
  logic            is_paused;
  logic            snap_valid;
  jrb_pkg::entry_t snap_entry;
  logic [9:0]      release_delay;
  frame_result_t   expected_q[$];

  int          error_count;
  int          idle_cycles;
  int          tx_gap_max;
  int          rx_stall_max;
  logic [31:0] stream_ms;

  jitter_reorder_buffer_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .seq_i              (seq_i),
    .media_time_i       (media_time_i),
    .payload_handle_i   (payload_handle_i),
    .payload_size_i     (payload_size_i),
    .now_ms_i           (now_ms_i),
    .pause_flag_i       (pause_flag_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .frame_seq_o        (frame_seq_o),
    .frame_media_time_o (frame_media_time_o),
    .frame_handle_o     (frame_handle_o),
    .frame_size_o       (frame_size_o),
    .occupancy_o        (occupancy_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic seq_is_before(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return d[15];
  endfunction

  function automatic frame_result_t predict_frame(logic [1:0] act, logic [15:0] seq,
                                                  logic [31:0] mtime, logic [31:0] hdl,
                                                  logic [15:0] sz, logic [31:0] now,
                                                  logic flag);
    frame_result_t   r;
    jrb_pkg::entry_t e;
    int              pos;
    logic [31:0]     age;
    r.status     = jrb_pkg::ST_NOTHING;
    r.seq        = '0;
    r.media_time = '0;
    r.handle     = '0;
    r.size       = '0;
    case (act)
      jrb_pkg::ACT_PUSH: begin
        if (held_q.size() >= jrb_pkg::CAPACITY) begin
          r.status = jrb_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_q.size() && seq_is_before(held_q[pos].seq, seq)) pos++;
          e.seq        = seq;
          e.media_time = mtime;
          e.handle     = hdl;
          e.size       = sz;
          e.arrival    = now;
          held_q.insert(pos, e);
          r.status = jrb_pkg::ST_DONE;
        end
      end
      jrb_pkg::ACT_POP: begin
        if (is_paused) begin
          if (snap_valid) begin
            r.status = jrb_pkg::ST_SNAPSHOT;
            e = snap_entry;
          end
        end else if (held_q.size() > 0) begin
          age = now - held_q[0].arrival;
          if (age >= release_delay) begin
            r.status = jrb_pkg::ST_RELEASED;
            e = held_q.pop_front();
          end
        end
        if (r.status != jrb_pkg::ST_NOTHING) begin
          r.seq        = e.seq;
          r.media_time = e.media_time;
          r.handle     = e.handle;
          r.size       = e.size;
        end
      end
      jrb_pkg::ACT_PAUSE: begin
        if (flag && !is_paused) begin
          snap_valid = held_q.size() > 0;
          if (snap_valid) snap_entry = held_q[0];
          is_paused = 1'b1;
        end else if (!flag && is_paused) begin
          is_paused = 1'b0;
        end
        r.status = jrb_pkg::ST_DONE;
      end
      default: ;
    endcase
    r.occupancy = 7'(held_q.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < MAX_PRINTED)
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [1:0] act, logic [15:0] seq, logic [31:0] mtime,
                           logic [31:0] hdl, logic [15:0] sz, logic [31:0] now,
                           logic flag);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i         = act;
    seq_i            = seq;
    media_time_i     = mtime;
    payload_handle_i = hdl;
    payload_size_i   = sz;
    now_ms_i         = now;
    pause_flag_i     = flag;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_frame(act, seq, mtime, hdl, sz, now, flag));
    @(negedge clk_i);
  endtask

  task automatic push_frame(logic [15:0] seq, logic [31:0] now);
    send_word(jrb_pkg::ACT_PUSH, seq, $urandom(), $urandom(), 16'($urandom()), now,
              1'($urandom()));
  endtask

  task automatic pop_frame(logic [31:0] now);
    send_word(jrb_pkg::ACT_POP, 16'($urandom()), $urandom(), $urandom(),
              16'($urandom()), now, 1'($urandom()));
  endtask

  task automatic set_pause(logic flag);
    send_word(jrb_pkg::ACT_PAUSE, 16'($urandom()), $urandom(), $urandom(),
              16'($urandom()), $urandom(), flag);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_release_delay(logic [9:0] value);
    drain();
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (value < jrb_pkg::MIN_DELAY_MS) release_delay = 10'(jrb_pkg::MIN_DELAY_MS);
    else if (value > jrb_pkg::MAX_DELAY_MS) release_delay = 10'(jrb_pkg::MAX_DELAY_MS);
    else release_delay = value;
  endtask

  // resume, then release every held frame with a time far enough ahead
  task automatic flush_buffer();
    if (is_paused) set_pause(1'b0);
    while (held_q.size() > 0) pop_frame(held_q[0].arrival + 32'(jrb_pkg::MAX_DELAY_MS));
  endtask

  // one frame alone in the buffer: too young by 1 ms, then exactly old enough
  task automatic check_release_edge(logic [9:0] setting, logic [31:0] arrival);
    set_release_delay(setting);
    push_frame(16'($urandom()), arrival);
    pop_frame(arrival + 32'(release_delay) - 32'd1);
    pop_frame(arrival + 32'(release_delay));
  endtask

  task automatic test_empty_edges();
    pop_frame(32'h0);
    set_pause(1'b1);
    set_pause(1'b1);
    pop_frame(32'hFFFF_FFFF);
    set_pause(1'b0);
    set_pause(1'b0);
    send_word(ACT_RESERVED, 16'hFFFF, '1, '1, 16'hFFFF, '1, 1'b1);
  endtask

  task automatic test_order_and_wrap();
    send_word(jrb_pkg::ACT_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h0,
              1'b1);
    send_word(jrb_pkg::ACT_PUSH, 16'h0000, 32'h0, 32'h0, 16'h0, 32'h0, 1'b0);
    // equal number lands ahead of the held one
    send_word(jrb_pkg::ACT_PUSH, 16'hFFFF, 32'h1234_5678, 32'h8765_4321, 16'h00AA, 32'h0,
              1'b0);
    send_word(jrb_pkg::ACT_PUSH, 16'h7FFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h8000, 32'h0,
              1'b0);
    flush_buffer();
  endtask

  task automatic test_release_age();
    check_release_edge(10'd100, 32'hFFFF_FFC0);  // age wraps past 2^32
    check_release_edge(10'd0, 32'h0000_0010);
    check_release_edge(10'd1023, 32'h8000_0000);
  endtask

  task automatic test_snapshot();
    push_frame(16'd500, 32'd0);
    push_frame(16'd499, 32'd0);
    set_pause(1'b1);
    push_frame(16'd498, 32'd0);  // new head, snapshot must stay
    set_pause(1'b1);
    pop_frame(32'd5000);
    set_pause(1'b0);
    pop_frame(32'd5000);
    flush_buffer();
  endtask

  task automatic test_config_extremes();
    set_release_delay(10'd19);
    set_release_delay(10'd1001);
    set_release_delay(10'd20);
    set_release_delay(10'd1000);
  endtask

  task automatic test_fill_to_full();
    logic [15:0] last_seq;
    last_seq = 16'($urandom());
    flush_buffer();
    repeat (jrb_pkg::CAPACITY + 6) begin
      if ($urandom_range(0, 3) != 0) last_seq = 16'($urandom());
      push_frame(last_seq, stream_ms);
    end
    flush_buffer();
  endtask

  task automatic test_stream_traffic(int n_items, logic [15:0] seq_start,
                                     logic [31:0] ms_start, int advance_max,
                                     logic [9:0] delay_setting);
    logic [15:0] seq_next;
    logic [15:0] seq;
    set_release_delay(delay_setting);
    seq_next  = seq_start;
    stream_ms = ms_start;
    repeat (n_items) begin
      stream_ms += $urandom_range(0, advance_max);
      if (held_q.size() < 48 && $urandom_range(0, 99) < 55) begin
        // jitter of a few frames around the running sequence number
        seq = seq_next + 16'($urandom_range(0, 6)) - 16'd3;
        push_frame(seq, stream_ms);
        seq_next += 16'($urandom_range(0, 2));
      end else begin
        pop_frame(stream_ms);
      end
    end
  endtask

  task automatic test_pause_traffic(int rounds);
    logic [15:0] seq_next;
    seq_next = 16'($urandom());
    repeat (rounds) begin
      if ($urandom_range(0, 3) == 0) flush_buffer();
      repeat ($urandom_range(0, 4)) begin
        stream_ms += $urandom_range(0, 40);
        push_frame(seq_next + 16'($urandom_range(0, 4)), stream_ms);
        seq_next += 16'd1;
      end
      set_pause(1'b1);
      repeat ($urandom_range(2, 8)) begin
        stream_ms += $urandom_range(0, 300);
        case ($urandom_range(0, 5))
          0:       push_frame(seq_next - 16'($urandom_range(0, 3)), stream_ms);
          1:       set_pause(1'b1);
          2:       set_pause(1'($urandom()));
          default: pop_frame(stream_ms);
        endcase
      end
      set_pause(1'b0);
      repeat ($urandom_range(0, 4)) begin
        stream_ms += $urandom_range(0, 400);
        pop_frame(stream_ms);
      end
    end
  endtask

  task automatic test_noise(int n_items);
    set_release_delay(10'($urandom()));
    repeat (n_items) begin
      send_word(2'($urandom_range(0, 3)), 16'($urandom()), $urandom(), $urandom(),
                16'($urandom()), $urandom(), 1'($urandom()));
    end
    flush_buffer();
  endtask

  // receiver: random stall before each result word
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_result
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing pending", 32'(status_o), 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (frame_seq_o !== want.seq)
          report_mismatch("frame_seq", 32'(frame_seq_o), 32'(want.seq));
        if (frame_media_time_o !== want.media_time)
          report_mismatch("frame_media_time", frame_media_time_o, want.media_time);
        if (frame_handle_o !== want.handle)
          report_mismatch("frame_handle", frame_handle_o, want.handle);
        if (frame_size_o !== want.size)
          report_mismatch("frame_size", 32'(frame_size_o), 32'(want.size));
        if (occupancy_o !== want.occupancy)
          report_mismatch("occupancy", 32'(occupancy_o), 32'(want.occupancy));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    action_i         = jrb_pkg::ACT_PUSH;
    seq_i            = '0;
    media_time_i     = '0;
    payload_handle_i = '0;
    payload_size_i   = '0;
    now_ms_i         = '0;
    pause_flag_i     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    is_paused        = 1'b0;
    snap_valid       = 1'b0;
    snap_entry       = '0;
    release_delay    = 10'(jrb_pkg::RESET_DELAY_MS);
    error_count      = 0;
    idle_cycles      = 0;
    stream_ms        = '0;
    tx_gap_max       = 3;
    rx_stall_max     = 3;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_edges();
    test_order_and_wrap();
    test_snapshot();
    test_release_age();
    test_config_extremes();

    tx_gap_max   = 0;
    rx_stall_max = 14;
    test_fill_to_full();
    tx_gap_max   = 14;
    rx_stall_max = 0;
    test_fill_to_full();

    tx_gap_max   = 0;
    rx_stall_max = 0;
    test_stream_traffic(300, 16'd100, 32'd0, 25, 10'd100);
    tx_gap_max   = 14;
    rx_stall_max = 14;
    test_stream_traffic(300, 16'hFFE0, 32'hFFFF_F000, 60, 10'd0);
    tx_gap_max   = 3;
    rx_stall_max = 14;
    test_stream_traffic(300, 16'h7FF0, 32'h7FFF_FF00, 40, 10'd1023);
    tx_gap_max   = 14;
    rx_stall_max = 2;
    test_stream_traffic(300, 16'($urandom()), $urandom(), 30, 10'($urandom()));

    tx_gap_max   = 5;
    rx_stall_max = 5;
    test_pause_traffic(20);
    tx_gap_max   = 0;
    rx_stall_max = 14;
    test_noise(150);

    drain();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/jrb_pkg.sv
design/jrb_cell.sv
design/jrb_chain.sv
design/jitter_reorder_buffer_core.sv
sim/jitter_reorder_buffer_core_tb.sv
